/* design/rtcm3_pkg.sv */
// Shared types and constants for the RTCM3 frame deframer.
// No dependencies; used by the parser, the output register and the top level.
`default_nettype none

package rtcm3_pkg;

   localparam int unsigned SHOW_WIDTH = 32;

   localparam logic [7:0]  PREAMBLE      = 8'hD3;
   localparam logic [24:0] CRC_POLY      = 25'h1864CFB;
   localparam logic [9:0]  CRC_BYTES     = 10'd3;

   typedef struct packed {
      logic [7:0]            frame_byte;
      logic                  first_of_frame;
      logic                  last_of_frame;
      logic                  crc_good;
      logic [SHOW_WIDTH-1:0] good_frames;
      logic [SHOW_WIDTH-1:0] bad_frames;
   } rsp_type;

endpackage

`default_nettype wire

/* design/rtcm3_in_reg.sv */
// Input register stage for the RTCM3 deframer.
// Holds one received byte until the parser can take it; no package use.
`default_nettype none

module rtcm3_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       advance,
   output logic            held_valid,
   output logic [7:0]      held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_data_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

`default_nettype wire

/* design/rtcm3_parser.sv */
// Frame parser: phase machine, length counter, CRC-24Q and frame counters.
// Depends on rtcm3_pkg for constants and the result struct.
`default_nettype none

module rtcm3_parser #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic [7:0] data_byte,
   output logic            emit,
   output rtcm3_pkg::rsp_type rsp
);

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_HDR2    = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_CRC     = 5'b10000
   } phase_type;

   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
      logic [24:0] c;
      c = {1'b0, crc ^ {b, 16'h0000}};
      for (int i = 0; i < 8; i++) begin
         c = {c[23:0], 1'b0};
         if (c[24]) begin
            c = c ^ rtcm3_pkg::CRC_POLY;
         end
      end
      return c[23:0];
   endfunction

   phase_type              phase_ff, phase_in;
   logic [1:0]             len_hi_ff, len_hi_in;
   logic [9:0]             remain_ff, remain_in;
   logic [23:0]            crc_ff, crc_in;
   logic [23:0]            rcv_ff, rcv_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;
   logic [COUNT_WIDTH-1:0] bad_ff, bad_in;
   logic [9:0]             length;
   logic [9:0]             remain_dec;
   logic [23:0]            crc_step;
   logic                   first, last, good;
   logic [rtcm3_pkg::SHOW_WIDTH-1:0] good_show, bad_show;

   assign length     = {len_hi_ff, data_byte};
   assign remain_dec = remain_ff - 10'd1;
   assign crc_step   = crc_byte((phase_ff == PH_HUNT) ? 24'h000000 : crc_ff, data_byte);

   always_comb begin
      phase_in  = phase_ff;
      len_hi_in = len_hi_ff;
      remain_in = remain_ff;
      crc_in    = crc_ff;
      rcv_in    = rcv_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      emit      = 1'b1;
      first     = 1'b0;
      last      = 1'b0;
      good      = 1'b0;
      case (phase_ff)
         PH_HUNT: begin
            if (data_byte == rtcm3_pkg::PREAMBLE) begin
               crc_in   = crc_step;
               rcv_in   = 24'h000000;
               first    = 1'b1;
               phase_in = PH_HDR1;
            end else begin
               emit = 1'b0;
            end
         end
         PH_HDR1: begin
            crc_in    = crc_step;
            len_hi_in = data_byte[1:0];
            phase_in  = PH_HDR2;
         end
         PH_HDR2: begin
            crc_in = crc_step;
            if (length == 10'd0) begin
               remain_in = rtcm3_pkg::CRC_BYTES;
               phase_in  = PH_CRC;
            end else begin
               remain_in = length;
               phase_in  = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_in    = crc_step;
            remain_in = remain_dec;
            if (remain_dec == 10'd0) begin
               remain_in = rtcm3_pkg::CRC_BYTES;
               phase_in  = PH_CRC;
            end
         end
         PH_CRC: begin
            rcv_in    = {rcv_ff[15:0], data_byte};
            remain_in = remain_dec;
            if (remain_dec == 10'd0) begin
               last     = 1'b1;
               phase_in = PH_HUNT;
               if (rcv_in == crc_ff) begin
                  good    = 1'b1;
                  good_in = good_ff + COUNT_WIDTH'(1);
               end else begin
                  bad_in = bad_ff + COUNT_WIDTH'(1);
               end
            end
         end
         default: begin
            emit     = 1'b0;
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         len_hi_ff <= 2'd0;
         remain_ff <= 10'd0;
         crc_ff    <= 24'h000000;
         rcv_ff    <= 24'h000000;
         good_ff   <= '0;
         bad_ff    <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         len_hi_ff <= len_hi_in;
         remain_ff <= remain_in;
         crc_ff    <= crc_in;
         rcv_ff    <= rcv_in;
         good_ff   <= good_in;
         bad_ff    <= bad_in;
      end
   end

   generate
      if (COUNT_WIDTH >= rtcm3_pkg::SHOW_WIDTH) begin : g_wide
         assign good_show = good_in[rtcm3_pkg::SHOW_WIDTH-1:0];
         assign bad_show  = bad_in[rtcm3_pkg::SHOW_WIDTH-1:0];
      end else begin : g_narrow
         assign good_show = {{(rtcm3_pkg::SHOW_WIDTH-COUNT_WIDTH){1'b0}}, good_in};
         assign bad_show  = {{(rtcm3_pkg::SHOW_WIDTH-COUNT_WIDTH){1'b0}}, bad_in};
      end
   endgenerate

   always_comb begin
      rsp.frame_byte     = data_byte;
      rsp.first_of_frame = first;
      rsp.last_of_frame  = last;
      rsp.crc_good       = good;
      rsp.good_frames    = good_show;
      rsp.bad_frames     = bad_show;
   end

endmodule

`default_nettype wire

/* design/rtcm3_out_reg.sv */
// Result register for the RTCM3 deframer.
// Depends on rtcm3_pkg for the result struct.
`default_nettype none

module rtcm3_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rtcm3_pkg::rsp_type rsp_next,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output rtcm3_pkg::rsp_type     rsp,
   output logic                   can_load
);

   logic               valid_ff, valid_in;
   rtcm3_pkg::rsp_type rsp_ff;

   assign can_load = !valid_ff || !rsp_stall;
   assign valid_in = can_load ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* design/rtcm3_frame_deframer_top.sv */
// Top level of the RTCM3 frame deframer with CRC-24Q check.
// Instantiates rtcm3_in_reg, rtcm3_parser and rtcm3_out_reg; uses rtcm3_pkg.
//
// Input channel (req_*): one raw stream byte per transfer. Bytes outside a
// frame other than the 0xD3 preamble are consumed and produce nothing.
// Result channel (rsp_*): every frame byte from preamble to last CRC byte,
// with first/last marks. On the last byte crc_good gives the verdict and
// the good/bad counters already include this frame. Bad frames are still
// streamed; the receiver drops them.
// Path: each input byte is held in the input register, then its result in
// the result register. Throughput: one byte per cycle, sustained while
// rsp_stall is low; the parser and byte-wide CRC network sit between them.
// Stall: when rsp_stall holds a full result register, the parser stops and
// req_stall rises once the input register is full; nothing is lost.
// Reset: synchronous; clears both valid flags, returns to preamble hunt and
// zeroes the CRC state and both frame counters.
`default_nettype none

module rtcm3_frame_deframer_top #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_first_of_frame,
   output logic             rsp_last_of_frame,
   output logic             rsp_crc_good,
   output logic [31:0]      rsp_good_frames,
   output logic [31:0]      rsp_bad_frames
);

   logic               held_valid;
   logic [7:0]         held_byte;
   logic               can_load;
   logic               fire;
   logic               emit;
   rtcm3_pkg::rsp_type rsp_next;
   rtcm3_pkg::rsp_type rsp_q;

   assign fire = held_valid && can_load;

   rtcm3_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (can_load),
      .held_valid    (held_valid),
      .held_byte     (held_byte)
   );

   rtcm3_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (held_byte),
      .emit      (emit),
      .rsp       (rsp_next)
   );

   rtcm3_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_q),
      .can_load  (can_load)
   );

   assign rsp_frame_byte     = rsp_q.frame_byte;
   assign rsp_first_of_frame = rsp_q.first_of_frame;
   assign rsp_last_of_frame  = rsp_q.last_of_frame;
   assign rsp_crc_good       = rsp_q.crc_good;
   assign rsp_good_frames    = rsp_q.good_frames;
   assign rsp_bad_frames     = rsp_q.bad_frames;

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_of_frame |-> !rsp_last_of_frame)
      else $error("frame opens and closes on the same byte");

   a_good_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_good |-> rsp_last_of_frame)
      else $error("crc verdict outside last byte");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
